// File: design/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/bps_pkg.sv
`timescale 1ns / 1ps
package bps_pkg;

   localparam int WORD_W       = 16;
   localparam int POS_W        = 9;
   localparam int COLOR_W      = 6;
   localparam int KIND_W       = 2;
   localparam int COUNT_W      = 2;
   localparam int SCROLL_W     = 4;
   localparam int CSR_DATA_W   = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int INPUT_PLANES = 6;

   localparam int FIRST_POSITION_DEFAULT = 0;
   localparam int PLANE_COUNT_DEFAULT    = 6;

   localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EOL    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HIRES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ODD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVEN  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_LORES = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_HIRES = 2'd2;

   typedef struct packed {
      logic commit;
      logic tick;
      logic clear;
      logic hires;
      logic load_odd;
      logic load_even;
   } plane_ctl_type;

   typedef struct packed {
      logic [COLOR_W-1:0] first_pixel;
      logic [COLOR_W-1:0] second_pixel;
      logic [COUNT_W-1:0] pixel_count;
      logic               line_active;
      logic [POS_W-1:0]   position;
   } rsp_word_type;

endpackage

// File: design/bps_ifs.sv
`timescale 1ns / 1ps
interface bps_req_if;
   logic                        valid;
   logic                        ready;
   logic [bps_pkg::KIND_W-1:0]  kind;
   logic [bps_pkg::WORD_W-1:0]  plane_word_one;
   logic [bps_pkg::WORD_W-1:0]  plane_word_two;
   logic [bps_pkg::WORD_W-1:0]  plane_word_three;
   logic [bps_pkg::WORD_W-1:0]  plane_word_four;
   logic [bps_pkg::WORD_W-1:0]  plane_word_five;
   logic [bps_pkg::WORD_W-1:0]  plane_word_six;

   modport source (
      output valid, kind, plane_word_one, plane_word_two, plane_word_three,
             plane_word_four, plane_word_five, plane_word_six,
      input  ready
   );
   modport sink (
      input  valid, kind, plane_word_one, plane_word_two, plane_word_three,
             plane_word_four, plane_word_five, plane_word_six,
      output ready
   );
endinterface

interface bps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bps_pkg::COLOR_W-1:0]  first_pixel;
   logic [bps_pkg::COLOR_W-1:0]  second_pixel;
   logic [bps_pkg::COUNT_W-1:0]  pixel_count;
   logic                         line_active;
   logic [bps_pkg::POS_W-1:0]    position;

   modport source (
      output valid, first_pixel, second_pixel, pixel_count, line_active, position,
      input  ready
   );
   modport sink (
      input  valid, first_pixel, second_pixel, pixel_count, line_active, position,
      output ready
   );
endinterface

// File: design/bps_planes.sv
`timescale 1ns / 1ps
module bps_planes #(
   parameter int PLANE_COUNT = bps_pkg::PLANE_COUNT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bps_pkg::plane_ctl_type       ctl,
   input  logic [bps_pkg::WORD_W-1:0]   words [bps_pkg::INPUT_PLANES],
   output logic [bps_pkg::COLOR_W-1:0]  first_pixel,
   output logic [bps_pkg::COLOR_W-1:0]  second_pixel
);
   import bps_pkg::*;

   // Planes past the input count never get data and read as zero.
   localparam int UsedPlanes = (PLANE_COUNT < INPUT_PLANES) ? PLANE_COUNT : INPUT_PLANES;

   logic [WORD_W-1:0] active_ff  [UsedPlanes];
   logic [WORD_W-1:0] active_in  [UsedPlanes];
   logic [WORD_W-1:0] pending_ff [UsedPlanes];
   logic [WORD_W-1:0] pending_in [UsedPlanes];

   for (genvar p = 0; p < UsedPlanes; p++) begin : g_plane
      // Even plane numbers belong to playfield one.
      localparam bit IsOdd = ((p % 2) == 0);
      logic load;
      logic [WORD_W-1:0] shifted;

      assign load    = IsOdd ? ctl.load_odd : ctl.load_even;
      assign shifted = ctl.hires ? {active_ff[p][WORD_W-3:0], 2'b00}
                                 : {active_ff[p][WORD_W-2:0], 1'b0};

      always_comb begin
         active_in[p]  = active_ff[p];
         pending_in[p] = pending_ff[p];
         if (ctl.commit) begin
            pending_in[p] = words[p];
         end else if (ctl.clear) begin
            active_in[p] = '0;
         end else if (ctl.tick) begin
            // Shift first, then reload from pending.
            active_in[p] = shifted;
            if (load) begin
               active_in[p]  = pending_ff[p];
               pending_in[p] = '0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            active_ff[p]  <= '0;
            pending_ff[p] <= '0;
         end else begin
            active_ff[p]  <= active_in[p];
            pending_ff[p] <= pending_in[p];
         end
      end
   end

   always_comb begin
      first_pixel  = '0;
      second_pixel = '0;
      for (int p = 0; p < UsedPlanes; p++) begin
         first_pixel[p]  = active_ff[p][WORD_W-1];
         second_pixel[p] = ctl.hires & active_ff[p][WORD_W-2];
      end
   end

endmodule

// File: design/bps_out_buf.sv
`timescale 1ns / 1ps
module bps_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bps_pkg::rsp_word_type  push_data,
   output logic                   room,
   bps_rsp_if.source              rsp
);
   import bps_pkg::*;

   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_word_type out_data_ff;
   rsp_word_type out_data_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_word_type skid_data_ff;
   rsp_word_type skid_data_in;
   logic         pop;

   assign pop  = out_valid_ff & rsp.ready;
   assign room = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            // Advance the older word from the skid stage.
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.first_pixel  = out_data_ff.first_pixel;
   assign rsp.second_pixel = out_data_ff.second_pixel;
   assign rsp.pixel_count  = out_data_ff.pixel_count;
   assign rsp.line_active  = out_data_ff.line_active;
   assign rsp.position     = out_data_ff.position;

endmodule

// File: design/bitplane_pixel_serializer.sv
`timescale 1ns / 1ps
// Channel   Dir  Words
// req_bus   in   commit plane words / position tick / end of line
// rsp_bus   out  one pixel word per position tick
// csr_*     in   hires_mode, odd_scroll, even_scroll writes
//
// One word per cycle in while ready; a tick's pixel word is registered on accept.
// Plane shift registers, position counter and line flag update at the accept edge.
// A two-entry output stage (register plus skid) keeps req_bus ready while one
// word waits; req_bus stalls only when both entries are full.
// Synchronous active-high reset clears planes, counter, flag and settings.
module bitplane_pixel_serializer #(
   parameter int FIRST_POSITION = bps_pkg::FIRST_POSITION_DEFAULT,
   parameter int PLANE_COUNT    = bps_pkg::PLANE_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   bps_req_if.sink                          req_bus,
   bps_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [bps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bps_pkg::*;

   localparam logic [POS_W-1:0] PosStart = POS_W'(FIRST_POSITION);

   logic                hires_ff;
   logic [SCROLL_W-1:0] odd_ff;
   logic [SCROLL_W-1:0] even_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic                line_ff;
   logic                line_in;

   logic                accept;
   logic                room;
   logic                odd_match;
   logic                even_match;
   plane_ctl_type       ctl;
   logic [WORD_W-1:0]   words [INPUT_PLANES];
   logic [COLOR_W-1:0]  first_pixel;
   logic [COLOR_W-1:0]  second_pixel;
   rsp_word_type        rsp_word;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid & room;

   always_ff @(posedge clock) begin
      if (reset) begin
         hires_ff <= 1'b0;
         odd_ff   <= '0;
         even_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HIRES: hires_ff <= csr_wdata[0];
            CSR_ODD:   odd_ff   <= csr_wdata[SCROLL_W-1:0];
            CSR_EVEN:  even_ff  <= csr_wdata[SCROLL_W-1:0];
            default:   ;
         endcase
      end
   end

   // Compare 3 low position bits in high resolution, 4 in low.
   assign odd_match  = hires_ff ? (pos_ff[2:0] == odd_ff[2:0])  : (pos_ff[3:0] == odd_ff);
   assign even_match = hires_ff ? (pos_ff[2:0] == even_ff[2:0]) : (pos_ff[3:0] == even_ff);

   always_comb begin
      ctl.commit    = accept & (req_bus.kind == KIND_COMMIT);
      ctl.tick      = accept & (req_bus.kind == KIND_TICK);
      ctl.clear     = accept & (req_bus.kind == KIND_EOL);
      ctl.hires     = hires_ff;
      ctl.load_odd  = odd_match;
      ctl.load_even = even_match;
   end

   assign words[0] = req_bus.plane_word_one;
   assign words[1] = req_bus.plane_word_two;
   assign words[2] = req_bus.plane_word_three;
   assign words[3] = req_bus.plane_word_four;
   assign words[4] = req_bus.plane_word_five;
   assign words[5] = req_bus.plane_word_six;

   bps_planes #(
      .PLANE_COUNT (PLANE_COUNT)
   ) u_planes (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .words        (words),
      .first_pixel  (first_pixel),
      .second_pixel (second_pixel)
   );

   always_comb begin
      pos_in  = pos_ff;
      line_in = line_ff;
      if (ctl.commit) begin
         line_in = 1'b1;
      end else if (ctl.clear) begin
         line_in = 1'b0;
         pos_in  = PosStart;
      end else if (ctl.tick) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= PosStart;
         line_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         line_ff <= line_in;
      end
   end

   always_comb begin
      rsp_word.first_pixel  = first_pixel;
      rsp_word.second_pixel = second_pixel;
      rsp_word.pixel_count  = hires_ff ? COUNT_HIRES : COUNT_LORES;
      rsp_word.line_active  = line_ff;
      rsp_word.position     = pos_ff;
   end

   bps_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (ctl.tick),
      .push_data (rsp_word),
      .room      (room),
      .rsp       (rsp_bus)
   );

endmodule

// File: design/bps_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bps_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [bps_pkg::COLOR_W-1:0]   first_pixel,
   input  logic [bps_pkg::COLOR_W-1:0]   second_pixel,
   input  logic [bps_pkg::COUNT_W-1:0]   pixel_count,
   input  logic                          line_active,
   input  logic [bps_pkg::POS_W-1:0]     position
);
   import bps_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(first_pixel) && $stable(second_pixel) && $stable(pixel_count) && $stable(line_active) && $stable(position), "stalled pixel word changed")
   `ASSERT_SAME(a_count_legal, clock, reset, rsp_valid, pixel_count == COUNT_LORES || pixel_count == COUNT_HIRES, "pixel count out of range")
   `ASSERT_SAME(a_lores_second, clock, reset, rsp_valid && pixel_count == COUNT_LORES, second_pixel == '0, "second pixel set in low resolution")
   `ASSERT_SAME(a_stall_cause, clock, reset, !req_ready, rsp_valid, "input stalled with no word waiting")

endmodule

bind bitplane_pixel_serializer bps_checker u_bps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .first_pixel  (rsp_bus.first_pixel),
   .second_pixel (rsp_bus.second_pixel),
   .pixel_count  (rsp_bus.pixel_count),
   .line_active  (rsp_bus.line_active),
   .position     (rsp_bus.position)
);

// File: verif/tb_bitplane_pixel_serializer.sv
`timescale 1ns / 1ps
module tb_bitplane_pixel_serializer;
   import bps_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [3:0]        LORES_MASK  = 4'hF;
   localparam logic [3:0]        HIRES_MASK  = 4'h7;
   localparam logic [POS_W-1:0]  START_POS   = POS_W'(FIRST_POSITION_DEFAULT);
   localparam int                SETTLE_CYCLES = 4;

   typedef logic [INPUT_PLANES-1:0][WORD_W-1:0] plane_set_type;

   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      logic [KIND_W-1:0]      kind;
      plane_set_type          words;
      bit                     typed;
      rsp_word_type           want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bps_req_if req_ch();
   bps_rsp_if rsp_ch();

   bitplane_pixel_serializer uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // serializer shadow state
   plane_set_type    active_plane;
   plane_set_type    pending_plane;
   logic [POS_W-1:0] next_position;
   logic             line_armed;
   logic             cfg_hires;
   logic [3:0]       cfg_odd_scroll;
   logic [3:0]       cfg_even_scroll;

   rsp_word_type pixel_words_due[$];
   stim_row_type directed_rows[$];
   int failures;
   int pixels_seen;
   int items_sent;
   bit burst_phase;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [COLOR_W-1:0] color_at(input int bit_idx);
      logic [COLOR_W-1:0] c;
      c = '0;
      for (int p = 0; p < INPUT_PLANES; p++) c[p] = active_plane[p][bit_idx];
      return c;
   endfunction

   task automatic serialize_word(input logic [KIND_W-1:0] k, input plane_set_type w,
                                 output bit made, output rsp_word_type r);
      int         cnt;
      logic [3:0] mask;
      logic [3:0] low_pos;
      made = 1'b0;
      r = '0;
      case (k)
         KIND_COMMIT: begin
            pending_plane = w;
            line_armed = 1'b1;
         end
         KIND_EOL: begin
            active_plane = '0;
            line_armed = 1'b0;
            next_position = START_POS;
         end
         KIND_TICK: begin
            made = 1'b1;
            cnt = cfg_hires ? 2 : 1;
            mask = cfg_hires ? HIRES_MASK : LORES_MASK;
            r.first_pixel  = color_at(15);
            r.second_pixel = cfg_hires ? color_at(14) : '0;
            r.pixel_count  = cfg_hires ? COUNT_HIRES : COUNT_LORES;
            r.line_active  = line_armed;
            r.position     = next_position;
            for (int p = 0; p < INPUT_PLANES; p++) active_plane[p] = active_plane[p] << cnt;
            // shift first, then reload on a scroll match
            low_pos = next_position[3:0] & mask;
            if (low_pos == (cfg_odd_scroll & mask)) begin
               for (int p = 0; p < INPUT_PLANES; p += 2) begin
                  active_plane[p] = pending_plane[p];
                  pending_plane[p] = '0;
               end
            end
            if (low_pos == (cfg_even_scroll & mask)) begin
               for (int p = 1; p < INPUT_PLANES; p += 2) begin
                  active_plane[p] = pending_plane[p];
                  pending_plane[p] = '0;
               end
            end
            next_position = next_position + 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic rsp_word_type pixel_word(input int first, input int second,
                                               input logic [COUNT_W-1:0] count,
                                               input bit act, input int pos);
      rsp_word_type r;
      r.first_pixel  = COLOR_W'(first);
      r.second_pixel = COLOR_W'(second);
      r.pixel_count  = count;
      r.line_active  = act;
      r.position     = POS_W'(pos);
      return r;
   endfunction

   function automatic stim_row_type item_row(input logic [KIND_W-1:0] k, input plane_set_type w,
                                             input bit typed, input rsp_word_type want);
      stim_row_type row;
      row.is_csr  = 1'b0;
      row.csr_idx = CSR_HIRES;
      row.csr_val = '0;
      row.kind    = k;
      row.words   = w;
      row.typed   = typed;
      row.want    = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      stim_row_type row;
      row = item_row(KIND_TICK, '0, 1'b0, '0);
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic plane_set_type rand_planes();
      plane_set_type w;
      for (int p = 0; p < INPUT_PLANES; p++) w[p] = rand_word();
      return w;
   endfunction

   function automatic int sender_gap();
      int r;
      if (burst_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   task automatic send_word(input logic [KIND_W-1:0] k, input plane_set_type w,
                            input bit typed, input rsp_word_type want);
      int           gap;
      bit           made;
      rsp_word_type predicted;
      gap = sender_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid            = 1'b1;
      req_ch.kind             = k;
      req_ch.plane_word_one   = w[0];
      req_ch.plane_word_two   = w[1];
      req_ch.plane_word_three = w[2];
      req_ch.plane_word_four  = w[3];
      req_ch.plane_word_five  = w[4];
      req_ch.plane_word_six   = w[5];
      do @(posedge clock); while (!req_ch.ready);
      serialize_word(k, w, made, predicted);
      if (made) pixel_words_due.push_back(typed ? want : predicted);
      if (k != KIND_UNUSED) items_sent++;
   endtask

   // drop valid and wait until the output side has drained
   task automatic settle_block();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pixel_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_HIRES: cfg_hires = val[0];
         CSR_ODD:   cfg_odd_scroll = val[SCROLL_W-1:0];
         CSR_EVEN:  cfg_even_scroll = val[SCROLL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_line(input int ticks);
      if ($urandom_range(0, 99) < 85) send_word(KIND_EOL, rand_planes(), 1'b0, '0);
      if ($urandom_range(0, 99) < 90) send_word(KIND_COMMIT, rand_planes(), 1'b0, '0);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 13) == 0) send_word(KIND_COMMIT, rand_planes(), 1'b0, '0);
         if ($urandom_range(0, 39) == 0) send_word(KIND_UNUSED, rand_planes(), 1'b0, '0);
         // broken line: end it early now and then
         if (ticks < 100 && $urandom_range(0, 59) == 0)
            send_word(KIND_EOL, rand_planes(), 1'b0, '0);
         send_word(KIND_TICK, rand_planes(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : pixel_check
      rsp_word_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         pixels_seen++;
         if (pixel_words_due.size() == 0) begin
            $error("pixel word with none expected: position %0d", rsp_ch.position);
            failures++;
         end else begin
            due = pixel_words_due.pop_front();
            if (rsp_ch.first_pixel !== due.first_pixel) begin
               $error("first_pixel: expected %0d, got %0d", due.first_pixel, rsp_ch.first_pixel);
               failures++;
            end
            if (rsp_ch.second_pixel !== due.second_pixel) begin
               $error("second_pixel: expected %0d, got %0d",
                      due.second_pixel, rsp_ch.second_pixel);
               failures++;
            end
            if (rsp_ch.pixel_count !== due.pixel_count) begin
               $error("pixel_count: expected %0d, got %0d", due.pixel_count, rsp_ch.pixel_count);
               failures++;
            end
            if (rsp_ch.line_active !== due.line_active) begin
               $error("line_active: expected %0d, got %0d", due.line_active, rsp_ch.line_active);
               failures++;
            end
            if (rsp_ch.position !== due.position) begin
               $error("position: expected %0d, got %0d", due.position, rsp_ch.position);
               failures++;
            end
         end
      end
   end

   // output side: random stalls, calm windows, one long hold-off
   initial begin
      int hold_left;
      int rx_cycles;
      int r;
      bit long_done;
      hold_left = 0;
      rx_cycles = 0;
      long_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycles++;
         if (!long_done && pixels_seen >= 150) begin
            long_done = 1'b1;
            hold_left = 80;
         end else if (hold_left == 0 && rx_cycles % 500 < 380) begin
            r = $urandom_range(0, 99);
            if (r < 20) hold_left = $urandom_range(1, 3);
            else if (r < 23) hold_left = $urandom_range(8, 30);
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      plane_set_type all_ones;
      plane_set_type mixed;
      int            phase_start;
      logic          ph_hires;
      logic [3:0]    ph_odd;
      logic [3:0]    ph_even;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_HIRES;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_COMMIT;
      req_ch.plane_word_one = '0;
      req_ch.plane_word_two = '0;
      req_ch.plane_word_three = '0;
      req_ch.plane_word_four = '0;
      req_ch.plane_word_five = '0;
      req_ch.plane_word_six = '0;
      active_plane = '0;
      pending_plane = '0;
      next_position = START_POS;
      line_armed = 1'b0;
      cfg_hires = 1'b0;
      cfg_odd_scroll = '0;
      cfg_even_scroll = '0;
      failures = 0;
      pixels_seen = 0;
      items_sent = 0;
      burst_phase = 1'b0;

      all_ones = '1;
      mixed = {16'hFEDC, 16'h1234, 16'hAAAA, 16'h5555, 16'h7FFE, 16'h8001};

      directed_rows.push_back(item_row(KIND_TICK, '0, 1'b1,
                                       pixel_word(0, 0, COUNT_LORES, 1'b0, 0)));
      directed_rows.push_back(item_row(KIND_COMMIT, all_ones, 1'b0, '0));
      // committed words wait for a scroll match
      directed_rows.push_back(item_row(KIND_TICK, '0, 1'b1,
                                       pixel_word(0, 0, COUNT_LORES, 1'b1, 1)));
      directed_rows.push_back(item_row(KIND_UNUSED, mixed, 1'b0, '0));
      // end of line keeps pending words
      directed_rows.push_back(item_row(KIND_EOL, '0, 1'b0, '0));
      directed_rows.push_back(item_row(KIND_TICK, '0, 1'b1,
                                       pixel_word(0, 0, COUNT_LORES, 1'b0, 0)));
      directed_rows.push_back(item_row(KIND_TICK, '0, 1'b1,
                                       pixel_word(63, 0, COUNT_LORES, 1'b0, 1)));
      directed_rows.push_back(item_row(KIND_TICK, '0, 1'b0, '0));
      directed_rows.push_back(item_row(KIND_COMMIT, '0, 1'b0, '0));
      directed_rows.push_back(item_row(KIND_TICK, '0, 1'b0, '0));
      directed_rows.push_back(csr_row(CSR_HIRES, 4'd1));
      directed_rows.push_back(csr_row(CSR_ODD, 4'd15));
      directed_rows.push_back(csr_row(CSR_EVEN, 4'd7));
      directed_rows.push_back(item_row(KIND_EOL, '0, 1'b0, '0));
      directed_rows.push_back(item_row(KIND_COMMIT, mixed, 1'b0, '0));
      repeat (9) directed_rows.push_back(item_row(KIND_TICK, '0, 1'b0, '0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle_block();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            send_word(directed_rows[i].kind, directed_rows[i].words,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         settle_block();
         case (ph)
            0: begin ph_hires = 1'b0; ph_odd = 4'd15; ph_even = 4'd15; end
            1: begin ph_hires = 1'b1; ph_odd = 4'd0;  ph_even = 4'd15; end
            2: begin ph_hires = 1'b0; ph_odd = 4'd3;  ph_even = 4'd9;  end
            3: begin ph_hires = 1'b1; ph_odd = 4'd15; ph_even = 4'd0;  end
            default: begin
               ph_hires = 1'($urandom_range(0, 1));
               ph_odd = 4'($urandom_range(0, 15));
               ph_even = 4'($urandom_range(0, 15));
            end
         endcase
         write_csr(CSR_HIRES, {3'b000, ph_hires});
         write_csr(CSR_ODD, ph_odd);
         write_csr(CSR_EVEN, ph_even);
         burst_phase = (ph % 2 == 1);
         phase_start = items_sent;
         // one line long enough to wrap the position counter
         if (ph == 2) run_line(520);
         while (items_sent - phase_start < 40) run_line($urandom_range(4, 40));
      end

      settle_block();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
